[sv/sbn_pkg.sv]
// ----------------------------------------------------------------------------
// sbn_pkg
// Shared types and register codes of the serial bus node responder.
// ----------------------------------------------------------------------------
package sbn_pkg;

  // register index, taken from paddr[2]
  localparam logic REG_BIT_PERIOD   = 1'b0;
  localparam logic REG_NODE_ADDRESS = 1'b1;

  localparam logic [15:0] BIT_PERIOD_RESET   = 16'd16;
  localparam logic [7:0]  NODE_ADDRESS_RESET = 8'd48;

  typedef struct packed {
    logic       drive_level;
    logic       drive_enable;
    logic       byte_done;
    logic [7:0] byte_value;
    logic       address_hit;
    logic       busy_res;
  } out_item_t;

endpackage

[sv/sbn_queue.sv]
// ----------------------------------------------------------------------------
// sbn_queue
// Two-entry register queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module sbn_queue #(
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;
  logic         do_push, do_pop;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[sv/sbn_engine.sv]
// ----------------------------------------------------------------------------
// sbn_engine
// Receive/reply sequencer: one line sample per step, one result word out.
// ----------------------------------------------------------------------------
module sbn_engine #(
  parameter int TICK_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               line_level,
  input  logic [15:0]        bit_period,
  input  logic [7:0]         node_address,
  output sbn_pkg::out_item_t item
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RX   = 2'd1;
  localparam logic [1:0] PH_TX   = 2'd2;

  localparam logic [3:0] BIT_LAST = 4'd10;

  localparam logic [7:0] REPLY_TEXT [8] = '{
    8'h6e, 8'h6f, 8'h64, 8'h65, 8'h20, 8'h00, 8'h00, 8'h0a
  };
  localparam logic [2:0] REPLY_ID_SLOT = 3'd6;

  logic [1:0]            phase_r, phase_nxt;
  logic [TICK_WIDTH-1:0] tick_r, tick_nxt;
  logic [3:0]            bit_r, bit_nxt;
  logic [7:0]            rx_shift_r, rx_shift_nxt;
  logic [2:0]            reply_r, reply_nxt;
  logic [7:0]            tx_shift_r, tx_shift_nxt;
  logic [7:0]            last_r, last_nxt;

  logic [31:0]           period_ext;
  logic [TICK_WIDTH-1:0] p, h, seg_len, seg_cnt;
  logic                  seg_end;
  logic [3:0]            bit_dec;

  function automatic logic [7:0] reply_byte(input logic [2:0] k, input logic [7:0] id);
    logic [7:0] b;
    b = REPLY_TEXT[k];
    if (k == REPLY_ID_SLOT) begin
      b = id;
    end
    return b;
  endfunction

  assign period_ext = {16'd0, bit_period};
  assign p          = period_ext[TICK_WIDTH-1:0];
  assign h          = p >> 1;
  assign seg_cnt    = tick_r + 1'b1;
  assign bit_dec    = bit_r - 4'd1;

  always_comb begin
    // start and stop-side waits are half periods while receiving
    if (phase_r == PH_RX && (bit_r == 4'd0 || bit_r >= BIT_LAST)) begin
      seg_len = h;
    end else begin
      seg_len = p;
    end
    seg_end = (seg_cnt >= seg_len);
  end

  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    bit_nxt      = bit_r;
    rx_shift_nxt = rx_shift_r;
    reply_nxt    = reply_r;
    tx_shift_nxt = tx_shift_r;
    last_nxt     = last_r;
    item         = '{drive_level: 1'b1, drive_enable: 1'b0, byte_done: 1'b0,
                     byte_value: 8'd0, address_hit: 1'b0, busy_res: 1'b0};

    unique case (phase_r)
      PH_RX: begin
        item.busy_res = 1'b1;
        if (seg_end) begin
          tick_nxt = '0;
          if (bit_r >= 4'd1 && bit_r <= 4'd8) begin
            rx_shift_nxt[bit_dec[2:0]] = line_level;
          end
          bit_nxt = bit_r + 4'd1;
          if (bit_r >= BIT_LAST) begin
            last_nxt          = rx_shift_r;
            item.byte_done    = 1'b1;
            item.address_hit  = (rx_shift_r == node_address);
            bit_nxt           = 4'd0;
            rx_shift_nxt      = 8'd0;
            if (rx_shift_r == node_address) begin
              phase_nxt    = PH_TX;
              reply_nxt    = 3'd0;
              tx_shift_nxt = reply_byte(3'd0, rx_shift_r);
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
        end else begin
          tick_nxt = seg_cnt;
        end
      end
      PH_TX: begin
        item.busy_res     = 1'b1;
        item.drive_enable = 1'b1;
        if (bit_r == 4'd0) begin
          item.drive_level = 1'b0;
        end else if (bit_r <= 4'd8) begin
          item.drive_level = tx_shift_r[bit_dec[2:0]];
        end
        if (seg_end) begin
          tick_nxt = '0;
          bit_nxt  = bit_r + 4'd1;
          if (bit_r >= BIT_LAST) begin
            bit_nxt   = 4'd0;
            reply_nxt = reply_r + 3'd1;
            if (reply_nxt == 3'd0) begin
              phase_nxt    = PH_IDLE;
              tx_shift_nxt = 8'd0;
            end else begin
              tx_shift_nxt = reply_byte(reply_nxt, last_r);
            end
          end
        end else begin
          tick_nxt = seg_cnt;
        end
      end
      default: begin
        // idle, and the unused code behaves as idle
        phase_nxt = PH_IDLE;
        if (!line_level) begin
          phase_nxt     = PH_RX;
          tick_nxt      = '0;
          bit_nxt       = 4'd0;
          rx_shift_nxt  = 8'd0;
          item.busy_res = 1'b1;
        end
      end
    endcase

    item.byte_value = last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      tick_r     <= '0;
      bit_r      <= 4'd0;
      rx_shift_r <= 8'd0;
      reply_r    <= 3'd0;
      tx_shift_r <= 8'd0;
      last_r     <= 8'd0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      tick_r     <= tick_nxt;
      bit_r      <= bit_nxt;
      rx_shift_r <= rx_shift_nxt;
      reply_r    <= reply_nxt;
      tx_shift_r <= tx_shift_nxt;
      last_r     <= last_nxt;
    end
  end

endmodule

[sv/serial_bus_node_responder_top.sv]
// ----------------------------------------------------------------------------
// serial_bus_node_responder_top
// Serial bus node: receives 8N1 bytes from line samples and answers its id.
// ----------------------------------------------------------------------------
// Each pushed word is one sample of the bus line and yields exactly one result
// word. The block takes a sample every clock cycle unless the input queue is
// full: a two-entry input queue feeds a sequencer that handles one sample per
// cycle while the result queue has room, and its result is registered in a
// two-entry output queue; either side may stall without losing words. Timing
// is counted in samples: bit_period_ticks per bit, half of it for the start
// and stop waits while receiving. On a byte equal to node_address the node
// drives the reply "node ", NUL, the byte, LF, each framed with a start bit, a
// stop bit and one idle bit. Registers: bit_period_ticks at 0x0, node_address
// at 0x4; write them only while the block is idle.
module serial_bus_node_responder_top #(
  parameter int TICK_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // sample queue
  input  logic        in_line_level,
  input  logic        push,
  output logic        full,
  // result queue
  output logic        out_drive_level,
  output logic        out_drive_enable,
  output logic        out_byte_done,
  output logic [7:0]  out_byte_value,
  output logic        out_address_hit,
  output logic        out_busy_res,
  output logic        empty,
  input  logic        pop,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]        period_r;
  logic [7:0]         node_r;
  logic               cfg_wr;

  logic               mid_line;
  logic               mid_empty;
  logic               res_full;
  logic               step;
  sbn_pkg::out_item_t eng_item;
  sbn_pkg::out_item_t res_item;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= sbn_pkg::BIT_PERIOD_RESET;
      node_r   <= sbn_pkg::NODE_ADDRESS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        sbn_pkg::REG_BIT_PERIOD:   period_r <= pwdata[15:0];
        sbn_pkg::REG_NODE_ADDRESS: node_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      sbn_pkg::REG_BIT_PERIOD:   prdata = {16'd0, period_r};
      sbn_pkg::REG_NODE_ADDRESS: prdata = {24'd0, node_r};
      default:                   prdata = 32'd0;
    endcase
  end

  sbn_queue #(.W(1)) u_in_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (in_line_level),
    .full      (full),
    .pop       (step),
    .pop_data  (mid_line),
    .empty     (mid_empty)
  );

  assign step = !mid_empty && !res_full;

  sbn_engine #(.TICK_WIDTH(TICK_WIDTH)) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .line_level   (mid_line),
    .bit_period   (period_r),
    .node_address (node_r),
    .item         (eng_item)
  );

  sbn_queue #(.W($bits(sbn_pkg::out_item_t))) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .push_data (eng_item),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (res_item),
    .empty     (empty)
  );

  assign out_drive_level  = res_item.drive_level;
  assign out_drive_enable = res_item.drive_enable;
  assign out_byte_done    = res_item.byte_done;
  assign out_byte_value   = res_item.byte_value;
  assign out_address_hit  = res_item.address_hit;
  assign out_busy_res     = res_item.busy_res;

  // a hit only comes with a completed byte
  a_hit_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_address_hit) |-> out_byte_done)
    else $error("address hit without byte done");

  // the line is only driven inside a busy span
  a_drive_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_drive_enable) |-> out_busy_res)
    else $error("drive enable outside busy");

  // released line reads idle high
  a_released_high: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_drive_enable) |-> out_drive_level)
    else $error("low level while line released");

  // the engine never steps into a full result queue
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> !res_full)
    else $error("result queue overrun");

endmodule

[tb/sv/sbn_reply_checker.sv]
// ----------------------------------------------------------------------------
// sbn_reply_checker
// Watches the sample and result queues and the register port of the serial
// bus node, predicts one result word per accepted line sample and compares
// every popped word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sbn_reply_checker
  import sbn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_line_level,
  input  logic        push,
  input  logic        full,
  input  logic        out_drive_level,
  input  logic        out_drive_enable,
  input  logic        out_byte_done,
  input  logic [7:0]  out_byte_value,
  input  logic        out_address_hit,
  input  logic        out_busy_res,
  input  logic        empty,
  input  logic        pop,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned mismatches,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    PH_LISTEN  = 2'd0,
    PH_RECEIVE = 2'd1,
    PH_REPLY   = 2'd2
  } line_phase_e;

  // reply text, byte k at [8*k +: 8]; byte 6 is replaced by the received id
  localparam logic [63:0] REPLY_TEXT = {8'd10, 8'd0, 8'd0, " ", "e", "d", "o", "n"};

  logic [15:0] period_q;
  logic [7:0]  node_q;

  line_phase_e phase_q;
  logic [15:0] tick_q;
  logic [3:0]  bit_q;
  logic [7:0]  rx_shift_q;
  logic [2:0]  reply_pos_q;
  logic [7:0]  tx_shift_q;
  logic [7:0]  last_byte_q;

  out_item_t   expected_words[$];
  out_item_t   oldest;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic logic [7:0] reply_char(input logic [2:0] k);
    if (k == 3'd6) return last_byte_q;
    return REPLY_TEXT[8*k +: 8];
  endfunction

  // one tick of a timed wait; a zero length still takes one tick
  function automatic logic wait_over(input logic [15:0] len);
    logic [15:0] c;
    c = tick_q + 16'd1;
    if (c >= len) begin
      tick_q = '0;
      return 1'b1;
    end
    tick_q = c;
    return 1'b0;
  endfunction

  function automatic out_item_t node_tick(input logic line);
    out_item_t   r;
    logic [15:0] half;
    logic [15:0] len;
    half = period_q >> 1;
    r = '0;
    r.drive_level = 1'b1;
    case (phase_q)
      PH_RECEIVE: begin
        r.busy_res = 1'b1;
        len = (bit_q == 4'd0 || bit_q >= 4'd10) ? half : period_q;
        if (wait_over(len)) begin
          if (bit_q >= 4'd1 && bit_q <= 4'd8) rx_shift_q[bit_q[2:0] - 3'd1] = line;
          bit_q = bit_q + 4'd1;
          if (bit_q > 4'd10) begin
            last_byte_q = rx_shift_q;
            r.byte_done = 1'b1;
            r.address_hit = (last_byte_q == node_q);
            bit_q = '0;
            rx_shift_q = '0;
            if (r.address_hit) begin
              phase_q = PH_REPLY;
              reply_pos_q = '0;
              tx_shift_q = reply_char(3'd0);
            end else begin
              phase_q = PH_LISTEN;
            end
          end
        end
      end
      PH_REPLY: begin
        r.busy_res = 1'b1;
        r.drive_enable = 1'b1;
        if (bit_q == 4'd0) r.drive_level = 1'b0;
        else if (bit_q <= 4'd8) r.drive_level = tx_shift_q[bit_q[2:0] - 3'd1];
        if (wait_over(period_q)) begin
          bit_q = bit_q + 4'd1;
          if (bit_q > 4'd10) begin
            bit_q = '0;
            reply_pos_q = reply_pos_q + 3'd1;
            if (reply_pos_q == 3'd0) begin
              phase_q = PH_LISTEN;
              tx_shift_q = '0;
            end else begin
              tx_shift_q = reply_char(reply_pos_q);
            end
          end
        end
      end
      default: begin
        phase_q = PH_LISTEN;
        if (!line) begin
          phase_q = PH_RECEIVE;
          tick_q = '0;
          bit_q = '0;
          rx_shift_q = '0;
          r.busy_res = 1'b1;
        end
      end
    endcase
    r.byte_value = last_byte_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      period_q = BIT_PERIOD_RESET;
      node_q = NODE_ADDRESS_RESET;
      phase_q = PH_LISTEN;
      tick_q = '0;
      bit_q = '0;
      rx_shift_q = '0;
      reply_pos_q = '0;
      tx_shift_q = '0;
      last_byte_q = '0;
      expected_words.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          $error("result word popped with nothing expected");
          mismatches++;
        end else begin
          oldest = expected_words.pop_front();
          check_field("drive_level", 8'(oldest.drive_level), 8'(out_drive_level));
          check_field("drive_enable", 8'(oldest.drive_enable), 8'(out_drive_enable));
          check_field("byte_done", 8'(oldest.byte_done), 8'(out_byte_done));
          check_field("byte_value", oldest.byte_value, out_byte_value);
          check_field("address_hit", 8'(oldest.address_hit), 8'(out_address_hit));
          check_field("busy_res", 8'(oldest.busy_res), 8'(out_busy_res));
        end
      end
      if (push && !full) expected_words.push_back(node_tick(in_line_level));
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_BIT_PERIOD:   period_q = pwdata[15:0];
          REG_NODE_ADDRESS: node_q = pwdata[7:0];
          default: ;
        endcase
      end
    end
    pending = expected_words.size();
  end

endmodule

[tb/sv/tb_serial_bus_node_responder_top.sv]
// ----------------------------------------------------------------------------
// tb_serial_bus_node_responder_top
// Drives line samples, register writes and result pops into the serial bus
// node; mostly well-formed 8N1 frames, some addressing the node, mixed with
// noise and cut-off frames, over several bit periods and node ids.
// ----------------------------------------------------------------------------
module tb_serial_bus_node_responder_top;
  import sbn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_QUOTA  = 110;
  localparam int unsigned RANDOM_ROUNDS = 6;

  logic        clk;
  logic        rst_n;
  logic        in_line_level;
  logic        push;
  logic        full;
  logic        out_drive_level;
  logic        out_drive_enable;
  logic        out_byte_done;
  logic [7:0]  out_byte_value;
  logic        out_address_hit;
  logic        out_busy_res;
  logic        empty;
  logic        pop;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycles;
  int unsigned counted;
  logic        tally;
  logic        steady;
  logic [7:0]  node_id;

  serial_bus_node_responder_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_line_level    (in_line_level),
    .push             (push),
    .full             (full),
    .out_drive_level  (out_drive_level),
    .out_drive_enable (out_drive_enable),
    .out_byte_done    (out_byte_done),
    .out_byte_value   (out_byte_value),
    .out_address_hit  (out_address_hit),
    .out_busy_res     (out_busy_res),
    .empty            (empty),
    .pop              (pop),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  sbn_reply_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_line_level    (in_line_level),
    .push             (push),
    .full             (full),
    .out_drive_level  (out_drive_level),
    .out_drive_enable (out_drive_enable),
    .out_byte_done    (out_byte_done),
    .out_byte_value   (out_byte_value),
    .out_address_hit  (out_address_hit),
    .out_busy_res     (out_busy_res),
    .empty            (empty),
    .pop              (pop),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic idle_roll();
    return !steady && ($urandom_range(99) < 19);
  endfunction

  always @(posedge clk) begin
    pop <= rst_n && !idle_roll();
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[serial_bus_node_responder_top] ERROR");
      $finish;
    end
  end

  task automatic send_sample(input logic lvl);
    while (idle_roll()) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_line_level <= lvl;
    @(posedge clk);
    while (full) @(posedge clk);
    if (tally) counted++;
  endtask

  task automatic send_level(input logic lvl, input int unsigned n);
    repeat (n) send_sample(lvl);
  endtask

  // start bit, eight data bits LSB first, stop bit; each bit lasts per samples
  task automatic send_frame(input logic [7:0] b, input int unsigned per);
    int unsigned w;
    w = (per == 0) ? 1 : per;
    send_level(1'b0, w);
    for (int i = 0; i < 8; i++) send_level(b[i], w);
    send_level(1'b1, w);
  endtask

  // the node ignores the line while it answers; fill that time with noise
  task automatic cover_reply(input int unsigned per);
    int unsigned w;
    w = (per == 0) ? 1 : per;
    tally = 1'b0;
    repeat (88 * w) send_sample(1'($urandom_range(1)));
    send_level(1'b1, 11 * w + 2);
    tally = 1'b1;
  endtask

  task automatic write_reg(input logic regsel, input logic [15:0] val);
    logic [31:0] w;
    w = $urandom;
    if (regsel == REG_BIT_PERIOD) w[15:0] = val;
    else w[7:0] = val[7:0];
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {regsel, 2'b00};
    pwdata <= w;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (regsel == REG_NODE_ADDRESS) node_id = val[7:0];
  endtask

  task automatic drain();
    push <= 1'b0;
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_round(input int unsigned per);
    int unsigned start;
    int unsigned r;
    logic [7:0]  b;
    start = counted;
    while (counted - start < PHASE_QUOTA) begin
      r = $urandom_range(99);
      if (r < 55) begin
        b = ($urandom_range(2) == 0) ? node_id : 8'($urandom_range(255));
        send_frame(b, per);
        if (b == node_id) cover_reply(per);
        else send_level(1'b1, $urandom_range(2 * per));
      end else if (r < 70) begin
        send_level(1'b1, $urandom_range(1, 4 * per));
      end else if (r < 85) begin
        repeat ($urandom_range(1, 6)) send_sample(1'($urandom_range(1)));
        send_level(1'b1, 11 * per + 2);
      end else begin
        // frame cut short after a few data bits
        send_level(1'b0, per);
        repeat ($urandom_range(1, 7)) send_level(1'($urandom_range(1)), per);
        send_level(1'b1, 11 * per + 2);
      end
    end
  endtask

  initial begin
    int unsigned per;
    rst_n = 1'b0;
    in_line_level = 1'b1;
    push = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cycles = 0;
    counted = 0;
    tally = 1'b1;
    steady = 1'b0;
    node_id = NODE_ADDRESS_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: all-ones id answered, all-zeros byte ignored
    write_reg(REG_BIT_PERIOD, 16'd2);
    write_reg(REG_NODE_ADDRESS, 16'h00FF);
    send_frame(8'hFF, 2);
    cover_reply(2);
    send_frame(8'h00, 2);
    send_level(1'b1, 3);
    drain();

    // half period of zero: start and stop waits take one tick
    write_reg(REG_BIT_PERIOD, 16'd1);
    write_reg(REG_NODE_ADDRESS, 16'h0000);
    send_level(1'b0, 10);
    cover_reply(1);
    drain();

    // zero period: every wait takes one tick
    write_reg(REG_BIT_PERIOD, 16'd0);
    send_level(1'b0, 3);
    send_sample(1'b1);
    send_level(1'b0, 6);
    cover_reply(1);
    drain();

    for (int k = 0; k < RANDOM_ROUNDS; k++) begin
      case (k)
        0: begin per = 3; write_reg(REG_NODE_ADDRESS, 16'h0000); end
        1: begin per = 2; write_reg(REG_NODE_ADDRESS, 16'h00FF); end
        4: begin per = 7; write_reg(REG_NODE_ADDRESS, 16'(NODE_ADDRESS_RESET)); end
        default: begin
          per = $urandom_range(2, 6);
          write_reg(REG_NODE_ADDRESS, 16'($urandom_range(255)));
        end
      endcase
      write_reg(REG_BIT_PERIOD, 16'(per));
      steady = (k == 2);
      random_round(per);
      drain();
    end
    steady = 1'b0;

    // longest bit period: park the node inside a frame, then shrink the
    // period so the running wait is already over
    write_reg(REG_BIT_PERIOD, 16'hFFFF);
    write_reg(REG_NODE_ADDRESS, 16'($urandom_range(255)));
    send_level(1'b0, 6);
    repeat (50) send_sample(1'($urandom_range(1)));
    drain();
    write_reg(REG_BIT_PERIOD, 16'd3);
    send_level(1'b1, 40);
    drain();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("[serial_bus_node_responder_top] OK");
    end else begin
      $display("[serial_bus_node_responder_top] ERROR");
    end
    $finish;
  end

endmodule
